>>> sv/kit_pkg.sv
// shared types and constants for the keyed item table
`timescale 1ns / 1ps
package kit_pkg;

	localparam int KIT_CAPACITY = 256;
	localparam int KEY_W        = 16;
	localparam int KIND_W       = 8;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_DELETE = 2'd1;
	localparam logic [1:0] MODE_LOOKUP = 2'd2;

	// one table slot as held in the memory
	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  key_x;
		logic [KEY_W-1:0]  key_y;
		logic [KIND_W-1:0] kind;
	} entry_t;

	// compare unit verdict on one slot
	typedef struct packed {
		logic hit;
		logic free;
	} cmp_res_t;

endpackage

>>> sv/kit_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module kit_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> sv/kit_cmp.sv
// key compare unit, judges one slot per cycle
`timescale 1ns / 1ps
module kit_cmp
	import kit_pkg::*;
(
	input  entry_t           entry,
	input  logic [KEY_W-1:0] key_x,
	input  logic [KEY_W-1:0] key_y,
	output cmp_res_t         res
);

	always_comb begin
		res.hit  = entry.valid && (entry.key_x == key_x) && (entry.key_y == key_y);
		res.free = !entry.valid;
	end

endmodule

>>> sv/keyed_item_table_unit.sv
// keyed item table: slot memory scanned by a shared compare unit
//
// channel   dir  handshake              fields
// in        in   in_valid / in_ready    mode, pos_x, pos_y, item_kind
// out       out  out_valid / out_ready  ok, table_full, found_kind
//
// each item is accepted in ST_IDLE, then ST_SCAN reads every slot in turn
// through the single memory read port, ST_DRAIN takes the last read data,
// and ST_FINISH writes back and registers the result.
// after reset a clearing pass writes every slot and marks all slots empty.
// the result waits in an output register; a new item is taken meanwhile and
// only the write-back cycle holds while that register is still full.
`timescale 1ns / 1ps
module keyed_item_table_unit
	import kit_pkg::*;
#(
	parameter int CAPACITY = KIT_CAPACITY
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               mode,
	input  logic signed [KEY_W-1:0]  pos_x,
	input  logic signed [KEY_W-1:0]  pos_y,
	input  logic [KIND_W-1:0]        item_kind,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     ok,
	output logic                     table_full,
	output logic [KIND_W-1:0]        found_kind
);

	localparam int AW = $clog2(CAPACITY);
	localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     cnt_q;
	logic [AW-1:0]     rd_idx_q;
	logic              rd_vld_q;

	logic [1:0]        op_mode_q;
	logic [KEY_W-1:0]  op_x_q;
	logic [KEY_W-1:0]  op_y_q;
	logic [KIND_W-1:0] op_kind_q;

	logic              hit_q;
	logic [AW-1:0]     hit_idx_q;
	logic [KIND_W-1:0] hit_kind_q;
	logic              free_q;
	logic [AW-1:0]     free_idx_q;

	logic              out_valid_q;
	logic              ok_q;
	logic              full_q;
	logic [KIND_W-1:0] found_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	entry_t            ram_wdata;
	entry_t            ram_rdata;
	cmp_res_t          cmp_res;

	logic              finish_go;
	logic              do_insert;
	logic              do_delete;

	logic              res_ok;
	logic              res_full;
	logic [KIND_W-1:0] res_found;

	kit_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(CAPACITY)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(cnt_q),
		.rdata(ram_rdata)
	);

	kit_cmp u_cmp (
		.entry(ram_rdata),
		.key_x(op_x_q),
		.key_y(op_y_q),
		.res  (cmp_res)
	);

	assign finish_go = (state_q == ST_FINISH) && (!out_valid_q || out_ready);
	assign do_insert = (op_mode_q == MODE_INSERT) && !hit_q && free_q;
	assign do_delete = (op_mode_q == MODE_DELETE) && hit_q;

	always_comb begin
		res_ok    = 1'b0;
		res_full  = 1'b0;
		res_found = '0;
		case (op_mode_q)
			MODE_INSERT: begin
				res_ok   = do_insert;
				res_full = !hit_q && !free_q;
			end
			MODE_DELETE: begin
				res_ok = hit_q;
			end
			MODE_LOOKUP: begin
				res_ok = hit_q;
				if (hit_q) begin
					res_found = hit_kind_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = '0;
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
		end else if (finish_go && do_insert) begin
			ram_we          = 1'b1;
			ram_waddr       = free_idx_q;
			ram_wdata.valid = 1'b1;
			ram_wdata.key_x = op_x_q;
			ram_wdata.key_y = op_y_q;
			ram_wdata.kind  = op_kind_q;
		end else if (finish_go && do_delete) begin
			// the whole entry is written as zero; valid low alone makes the compare ignore the key bits
			ram_we    = 1'b1;
			ram_waddr = hit_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			rd_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_q <= (state_q == ST_SCAN);
			rd_idx_q <= cnt_q;

			if (finish_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			// fold in the slot read last cycle, first match and first hole win
			if (rd_vld_q) begin
				if (cmp_res.hit && !hit_q) begin
					hit_q      <= 1'b1;
					hit_idx_q  <= rd_idx_q;
					hit_kind_q <= ram_rdata.kind;
				end
				if (cmp_res.free && !free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= rd_idx_q;
				end
			end

			unique case (state_q)
				ST_CLEAR: begin
					if (cnt_q == LAST_ADDR) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						op_mode_q <= mode;
						op_x_q    <= $unsigned(pos_x);
						op_y_q    <= $unsigned(pos_y);
						op_kind_q <= item_kind;
						hit_q     <= 1'b0;
						free_q    <= 1'b0;
						cnt_q     <= '0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cnt_q == LAST_ADDR) begin
						cnt_q   <= '0;
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (finish_go) begin
						ok_q    <= res_ok;
						full_q  <= res_full;
						found_q <= res_found;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign ok         = ok_q;
	assign table_full = full_q;
	assign found_kind = found_q;

endmodule
